FILE: rtl/core/kls_pkg.sv
// Shared types, constants and helper functions for the keyword lexer.
package kls_pkg;

  localparam int POS_BITS    = 16;
  localparam int MAX_WORD    = 7;
  localparam int LEN_W       = 16;
  localparam int START_W     = 16;
  localparam int WORD_IDX_W  = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef enum logic [2:0] {
    M_IDLE,
    M_NUM,
    M_WORD,
    M_STR,
    M_LOOK
  } lex_mode_t;

  localparam logic [4:0] KIND_NUMBER       = 5'd0;
  localparam logic [4:0] KIND_STRING       = 5'd1;
  localparam logic [4:0] KIND_EQ           = 5'd2;
  localparam logic [4:0] KIND_EQEQ         = 5'd3;
  localparam logic [4:0] KIND_LBRACE       = 5'd4;
  localparam logic [4:0] KIND_RBRACE       = 5'd5;
  localparam logic [4:0] KIND_COMMA        = 5'd6;
  localparam logic [4:0] KIND_OP           = 5'd7;
  localparam logic [4:0] KIND_GT           = 5'd8;
  localparam logic [4:0] KIND_LT           = 5'd9;
  localparam logic [4:0] KIND_GE           = 5'd10;
  localparam logic [4:0] KIND_LE           = 5'd11;
  localparam logic [4:0] KIND_NE           = 5'd12;
  localparam logic [4:0] KIND_UNKNOWN      = 5'd13;
  localparam logic [4:0] KIND_EXIT         = 5'd14;
  localparam logic [4:0] KIND_FN           = 5'd15;
  localparam logic [4:0] KIND_GLOBAL       = 5'd16;
  localparam logic [4:0] KIND_WRITE        = 5'd17;
  localparam logic [4:0] KIND_REGISTER     = 5'd18;
  localparam logic [4:0] KIND_RETURN       = 5'd19;
  localparam logic [4:0] KIND_PUSH         = 5'd20;
  localparam logic [4:0] KIND_POP          = 5'd21;
  localparam logic [4:0] KIND_USING        = 5'd22;
  localparam logic [4:0] KIND_IF           = 5'd23;
  localparam logic [4:0] KIND_UNTERMINATED = 5'd24;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef logic [MAX_WORD-1:0][7:0] word_prefix_t;

  typedef struct packed {
    logic [4:0]         kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic [7:0]         chr;
    logic [2:0]         reg_idx;
  } token_t;

  // Tokens caused by one input byte; tok[0] goes out first.
  typedef struct packed {
    logic            two;
    token_t [1:0]    tok;
  } bundle_t;

  typedef struct packed {
    logic [4:0] kind;
    logic [2:0] reg_idx;
  } word_hit_t;

  // Keyword table, text left-aligned and space padded.
  localparam int WORD_COUNT = 17;
  localparam int KW_CHARS   = 6;
  localparam logic [8*KW_CHARS-1:0] KW_TEXT [WORD_COUNT] = '{
    "exit  ", "fn    ", "global", "write ", "RAX   ", "RDI   ", "RSI   ",
    "RDX   ", "R10   ", "R8    ", "R9    ", "RBX   ", "return", "push  ",
    "pop   ", "using ", "if    "
  };
  localparam logic [2:0] KW_LEN [WORD_COUNT] = '{
    3'd4, 3'd2, 3'd6, 3'd5, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd3,
    3'd6, 3'd4, 3'd3, 3'd5, 3'd2
  };
  localparam logic [4:0] KW_KIND [WORD_COUNT] = '{
    KIND_EXIT, KIND_FN, KIND_GLOBAL, KIND_WRITE, KIND_REGISTER, KIND_REGISTER,
    KIND_REGISTER, KIND_REGISTER, KIND_REGISTER, KIND_REGISTER, KIND_REGISTER,
    KIND_REGISTER, KIND_RETURN, KIND_PUSH, KIND_POP, KIND_USING, KIND_IF
  };
  localparam logic [2:0] KW_REG [WORD_COUNT] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0
  };

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return is_digit(b) || ((b >= 8'h61) && (b <= 8'h7A)) ||
           ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic is_look(input logic [7:0] b);
    return (b == CH_EQ) || (b == CH_GT) || (b == CH_LT) || (b == CH_BANG);
  endfunction

  function automatic logic is_single(input logic [7:0] b);
    return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_COMMA) ||
           (b == CH_PLUS) || (b == CH_MINUS) || (b == CH_STAR) || (b == CH_SLASH);
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] b);
    logic [4:0] k;
    unique case (b)
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_COMMA:  k = KIND_COMMA;
      default:   k = KIND_OP;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] look_alone_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      CH_EQ:   k = KIND_EQ;
      CH_GT:   k = KIND_GT;
      CH_LT:   k = KIND_LT;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] look_pair_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      CH_EQ:   k = KIND_EQEQ;
      CH_GT:   k = KIND_GE;
      CH_LT:   k = KIND_LE;
      default: k = KIND_NE;
    endcase
    return k;
  endfunction

  function automatic word_hit_t word_lookup(input word_prefix_t pfx,
                                            input logic [LEN_W-1:0] len);
    word_hit_t hit;
    logic      match;
    hit.kind    = KIND_UNKNOWN;
    hit.reg_idx = 3'd0;
    for (int e = 0; e < WORD_COUNT; e++) begin
      match = (len == LEN_W'(KW_LEN[e]));
      for (int i = 0; i < KW_CHARS; i++) begin
        if ((i < int'(KW_LEN[e])) && (pfx[i] != KW_TEXT[e][8*(KW_CHARS-1-i) +: 8])) begin
          match = 1'b0;
        end
      end
      if (match) begin
        hit.kind    = KW_KIND[e];
        hit.reg_idx = KW_REG[e];
      end
    end
    return hit;
  endfunction

  function automatic token_t mk_tok(input logic [4:0]          kind,
                                    input logic [POS_BITS-1:0] start,
                                    input logic [LEN_W-1:0]    len,
                                    input logic [7:0]          chr,
                                    input logic [2:0]          reg_idx);
    token_t t;
    t.kind    = kind;
    t.start   = START_W'(start);
    t.length  = len;
    t.chr     = chr;
    t.reg_idx = reg_idx;
    return t;
  endfunction

endpackage

FILE: rtl/core/kls_char_if.sv
// Byte channel into the lexer: one source byte and end-of-text flag per transaction.
interface kls_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_text;

  modport source (output valid, output char_byte, output end_of_text, input ready);
  modport sink (input valid, input char_byte, input end_of_text, output ready);
endinterface

FILE: rtl/core/kls_token_if.sv
// Token channel out of the lexer: one token per transaction.
interface kls_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [7:0]  token_char;
  logic [2:0]  register_index;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output token_char, output register_index,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input token_char, input register_index,
                input last_of_run, output ready);
endinterface

FILE: rtl/core/keyword_lexer_stream.sv
// Streaming keyword lexer: source bytes in, classified tokens out.
// Tokens of each byte are registered in the bundle queue before they are offered.
// Throughput: one byte per cycle in while the queue has room; one token per cycle out
// while ready; a 4-bundle queue absorbs bytes whose two tokens hold the output port.
// Reset: synchronous rst empties the queue and returns the lexer to idle at offset 0;
// the word prefix store is not cleared.
module keyword_lexer_stream import kls_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  kls_char_if.sink    chars,
  kls_token_if.source tokens
);

  logic    q_ready;
  logic    q_push;
  bundle_t q_bundle;
  logic    head_valid;
  bundle_t head;
  logic    pop;

  kls_front u_front (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_bundle (q_bundle)
  );

  kls_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_bundle),
    .ready      (q_ready),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  kls_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .tokens     (tokens)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !tokens.valid)
    else $error("token offered right after reset");

  a_push_room: assert property (@(posedge clk) disable iff (rst) q_push |-> q_ready)
    else $error("bundle pushed into full queue");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (tokens.valid && tokens.ready && !tokens.last_of_run) |=> tokens.valid)
    else $error("second token of a bundle missing");

  a_reg_kind: assert property (@(posedge clk) disable iff (rst)
    (tokens.valid && (tokens.register_index != 3'd0)) |->
      (tokens.token_kind == KIND_REGISTER))
    else $error("register index on non-register token");

endmodule

FILE: rtl/core/kls_front.sv
// Front end: accepts bytes, runs the lexer state machine, builds token bundles.
module kls_front import kls_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  kls_char_if.sink chars,
  input  logic    q_ready,
  output logic    q_push,
  output bundle_t q_bundle
);

  lex_mode_t           mode, mode_next, mid_mode;
  logic [POS_BITS-1:0] pos, pos_next;
  logic [POS_BITS-1:0] pstart, pstart_next, mid_start;
  logic [LEN_W-1:0]    plen, plen_next, mid_len;
  logic [7:0]          pfc, pfc_next, mid_fc;
  word_prefix_t        prefix, mid_prefix;

  logic       accept;
  logic [7:0] b;
  logic       eot;
  logic       take_fresh;
  logic       grow_en;

  token_t [1:0] toks;
  logic [1:0]   cnt;
  word_hit_t    hit_old, hit_mid;

  assign b            = chars.char_byte;
  assign eot          = chars.end_of_text;
  assign chars.ready  = q_ready;
  assign accept       = chars.valid && q_ready;

  // Effect of the byte on the pending token, before end-of-text handling.
  always_comb begin
    mid_mode   = mode;
    mid_start  = pstart;
    mid_len    = plen;
    mid_fc     = pfc;
    mid_prefix = prefix;
    take_fresh = 1'b0;
    grow_en    = 1'b0;
    unique case (mode)
      M_STR: begin
        if (b == CH_QUOTE) begin
          mid_mode = M_IDLE;
        end else begin
          if (plen == '0) mid_fc = b;
          grow_en = 1'b1;
        end
      end
      M_NUM: begin
        if (is_digit(b)) grow_en = 1'b1;
        else take_fresh = 1'b1;
      end
      M_WORD: begin
        if (is_alnum(b)) grow_en = 1'b1;
        else take_fresh = 1'b1;
      end
      M_LOOK: begin
        if (b == CH_EQ) mid_mode = M_IDLE;
        else take_fresh = 1'b1;
      end
      default: take_fresh = 1'b1;
    endcase

    if (grow_en) begin
      if (plen < LEN_W'(MAX_WORD)) mid_prefix[plen[WORD_IDX_W-1:0]] = b;
      if (plen != LEN_MAX) mid_len = plen + 1'b1;
    end

    if (take_fresh) begin
      if (is_space(b) || is_single(b)) begin
        mid_mode = M_IDLE;
      end else if (b == CH_QUOTE) begin
        mid_mode  = M_STR;
        mid_start = pos + 1'b1;
        mid_len   = '0;
        mid_fc    = '0;
      end else begin
        mid_mode      = is_digit(b) ? M_NUM : (is_look(b) ? M_LOOK : M_WORD);
        mid_start     = pos;
        mid_len       = LEN_W'(1);
        mid_fc        = b;
        mid_prefix[0] = b;
      end
    end
  end

  always_comb begin
    if (eot) begin
      mode_next   = M_IDLE;
      pos_next    = '0;
      pstart_next = '0;
      plen_next   = '0;
      pfc_next    = '0;
    end else begin
      mode_next   = mid_mode;
      pos_next    = pos + 1'b1;
      pstart_next = mid_start;
      plen_next   = mid_len;
      pfc_next    = mid_fc;
    end
  end

  assign hit_old = word_lookup(prefix, plen);
  assign hit_mid = word_lookup(mid_prefix, mid_len);

  // Tokens caused by this byte, in order.
  always_comb begin
    toks = '0;
    cnt  = 2'd0;
    unique case (mode)
      M_STR: begin
        if (b == CH_QUOTE) begin
          toks[cnt[0]] = mk_tok(KIND_STRING, pstart, plen, pfc, 3'd0);
          cnt = cnt + 2'd1;
        end
      end
      M_NUM: begin
        if (!is_digit(b)) begin
          toks[cnt[0]] = mk_tok(KIND_NUMBER, pstart, plen, pfc, 3'd0);
          cnt = cnt + 2'd1;
        end
      end
      M_WORD: begin
        if (!is_alnum(b)) begin
          toks[cnt[0]] = mk_tok(hit_old.kind, pstart, plen, pfc, hit_old.reg_idx);
          cnt = cnt + 2'd1;
        end
      end
      M_LOOK: begin
        if (b == CH_EQ) begin
          toks[cnt[0]] = mk_tok(look_pair_kind(pfc), pstart, LEN_W'(2), pfc, 3'd0);
        end else begin
          toks[cnt[0]] = mk_tok(look_alone_kind(pfc), pstart, LEN_W'(1), pfc, 3'd0);
        end
        cnt = cnt + 2'd1;
      end
      default: ;
    endcase

    if (take_fresh && is_single(b)) begin
      toks[cnt[0]] = mk_tok(single_kind(b), pos, LEN_W'(1), b, 3'd0);
      cnt = cnt + 2'd1;
    end

    if (eot) begin
      unique case (mid_mode)
        M_STR: begin
          toks[cnt[0]] = mk_tok(KIND_UNTERMINATED, mid_start, mid_len, mid_fc, 3'd0);
          cnt = cnt + 2'd1;
        end
        M_NUM: begin
          toks[cnt[0]] = mk_tok(KIND_NUMBER, mid_start, mid_len, mid_fc, 3'd0);
          cnt = cnt + 2'd1;
        end
        M_WORD: begin
          toks[cnt[0]] = mk_tok(hit_mid.kind, mid_start, mid_len, mid_fc, hit_mid.reg_idx);
          cnt = cnt + 2'd1;
        end
        M_LOOK: begin
          toks[cnt[0]] = mk_tok(look_alone_kind(mid_fc), mid_start, LEN_W'(1), mid_fc, 3'd0);
          cnt = cnt + 2'd1;
        end
        default: ;
      endcase
    end
  end

  assign q_push       = accept && (cnt != 2'd0);
  assign q_bundle.two = cnt[1];
  assign q_bundle.tok = toks;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      pos    <= '0;
      pstart <= '0;
      plen   <= '0;
      pfc    <= '0;
    end else if (accept) begin
      mode   <= mode_next;
      pos    <= pos_next;
      pstart <= pstart_next;
      plen   <= plen_next;
      pfc    <= pfc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prefix <= mid_prefix;
    end
  end

endmodule

FILE: rtl/core/kls_queue.sv
// Bundle queue between the lexer front end and the token sequencer.
module kls_queue import kls_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    ready,
  output logic    head_valid,
  output bundle_t head,
  input  logic    pop
);

  bundle_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QPTR_W:0]     count, count_next;
  logic                do_push, do_pop;

  assign ready      = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) count_next = count + 1'b1;
    else if (do_pop && !do_push) count_next = count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/core/kls_back.sv
// Back end: sends the one or two tokens of each queued bundle in order.
module kls_back import kls_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  bundle_t       head,
  output logic          pop,
  kls_token_if.source   tokens
);

  logic   sel;
  logic   last;
  logic   fire;
  token_t cur;

  assign cur    = head.tok[sel];
  assign last   = !head.two || sel;
  assign fire   = tokens.valid && tokens.ready;
  assign pop    = fire && last;

  assign tokens.valid          = head_valid;
  assign tokens.token_kind     = cur.kind;
  assign tokens.token_start    = cur.start;
  assign tokens.token_length   = cur.length;
  assign tokens.token_char     = cur.chr;
  assign tokens.register_index = cur.reg_idx;
  assign tokens.last_of_run    = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (fire) begin
      sel <= !last;
    end
  end

endmodule

FILE: tb/sv/keyword_lexer_stream_tb.sv
// Self-checking testbench for keyword_lexer_stream: byte stream in, predicted tokens compared.
module keyword_lexer_stream_tb;
  import kls_pkg::*;

  localparam int PRED         = -1;
  localparam int DIR_ROWS     = 25;
  localparam int RANDOM_ITEMS = 1200;
  localparam int STALL_LIMIT  = 2000;
  localparam int PRESSURE_AT  = 300;
  localparam int HOLD_CYCLES  = 150;
  localparam int KW_TOTAL     = 17;
  localparam int LEN_SAT      = 65535;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [7:0]  chr;
    logic [2:0]  reg_idx;
    logic        last;
  } lexeme_t;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
    int         n_typed;
    lexeme_t    t0;
    lexeme_t    t1;
  } stim_row_t;

  localparam lexeme_t NO_TOK = '0;

  logic clk;
  logic rst;

  kls_char_if  chars ();
  kls_token_if tokens ();

  keyword_lexer_stream dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars),
    .tokens (tokens)
  );

  string      kw_text [KW_TOTAL] = '{
    "exit", "fn", "global", "write", "RAX", "RDI", "RSI", "RDX", "R10", "R8", "R9",
    "RBX", "return", "push", "pop", "using", "if"
  };
  logic [4:0] kw_kind [KW_TOTAL] = '{
    KIND_EXIT, KIND_FN, KIND_GLOBAL, KIND_WRITE, KIND_REGISTER, KIND_REGISTER,
    KIND_REGISTER, KIND_REGISTER, KIND_REGISTER, KIND_REGISTER, KIND_REGISTER,
    KIND_REGISTER, KIND_RETURN, KIND_PUSH, KIND_POP, KIND_USING, KIND_IF
  };
  logic [2:0] kw_reg [KW_TOTAL] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0
  };
  logic [7:0] look_chars [4]   = '{CH_EQ, CH_GT, CH_LT, CH_BANG};
  logic [7:0] single_chars [7] = '{CH_LBRACE, CH_RBRACE, CH_COMMA, CH_PLUS, CH_MINUS,
                                   CH_STAR, CH_SLASH};

  // lexer state mirror
  lex_mode_t           lx_mode  = M_IDLE;
  logic [POS_BITS-1:0] lx_pos   = '0;
  logic [POS_BITS-1:0] lx_start = '0;
  int                  lx_len   = 0;
  logic [7:0]          lx_first = 8'd0;
  logic [7:0]          lx_prefix [MAX_WORD];

  lexeme_t   byte_tokens [$];
  lexeme_t   expected_tokens [$];
  stim_row_t stim_q [$];
  stim_row_t dir_tab [DIR_ROWS];

  int stim_idx;
  int calm_from;
  int src_gap;
  int snk_gap;
  int mismatches;
  int stall_cycles;
  logic hold_sink;
  logic draining;

  function automatic lexeme_t lx(logic [4:0] kind, logic [15:0] start, logic [15:0] len,
                                 logic [7:0] chr, logic [2:0] ri, logic last);
    lexeme_t t;
    t.kind    = kind;
    t.start   = start;
    t.length  = len;
    t.chr     = chr;
    t.reg_idx = ri;
    t.last    = last;
    return t;
  endfunction

  function automatic logic num_char(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic word_char(logic [7:0] b);
    return num_char(b) || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic blank_char(logic [7:0] b);
    return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
  endfunction

  task automatic put_tok(logic [4:0] kind, logic [15:0] start, int len, logic [7:0] chr,
                         logic [2:0] ri);
    byte_tokens = {byte_tokens, lx(kind, start, 16'((len > LEN_SAT) ? LEN_SAT : len), chr,
                                   ri, 1'b0)};
  endtask

  task automatic grow_lexeme(logic [7:0] b);
    if (lx_len < MAX_WORD) lx_prefix[lx_len] = b;
    if (lx_len < LEN_SAT) lx_len++;
  endtask

  task automatic open_lexeme(lex_mode_t mode, logic [7:0] b);
    lx_mode  = mode;
    lx_start = lx_pos;
    lx_len   = 0;
    lx_first = b;
    grow_lexeme(b);
  endtask

  task automatic put_word();
    logic [4:0] kind;
    logic [2:0] ri;
    logic       hit;
    logic [7:0] kc;
    kind = KIND_UNKNOWN;
    ri   = 3'd0;
    if (lx_len <= MAX_WORD) begin
      for (int e = 0; e < KW_TOTAL; e++) begin
        if (kind == KIND_UNKNOWN && kw_text[e].len() == lx_len) begin
          hit = 1'b1;
          for (int i = 0; i < lx_len; i++) begin
            kc = kw_text[e][i];
            if (kc != lx_prefix[i]) hit = 1'b0;
          end
          if (hit) begin
            kind = kw_kind[e];
            ri   = kw_reg[e];
          end
        end
      end
    end
    put_tok(kind, lx_start, lx_len, lx_first, ri);
  endtask

  task automatic put_look_alone();
    logic [4:0] kind;
    case (lx_first)
      CH_EQ:   kind = KIND_EQ;
      CH_GT:   kind = KIND_GT;
      CH_LT:   kind = KIND_LT;
      default: kind = KIND_UNKNOWN;
    endcase
    put_tok(kind, lx_start, 1, lx_first, 3'd0);
  endtask

  task automatic start_token(logic [7:0] b);
    if (num_char(b)) begin
      open_lexeme(M_NUM, b);
    end else if (blank_char(b)) begin
      lx_mode = M_IDLE;
    end else if (b == CH_QUOTE) begin
      lx_mode  = M_STR;
      lx_start = lx_pos + 1'b1;
      lx_len   = 0;
      lx_first = 8'd0;
    end else if (b == CH_EQ || b == CH_GT || b == CH_LT || b == CH_BANG) begin
      open_lexeme(M_LOOK, b);
    end else if (b == CH_LBRACE) begin
      put_tok(KIND_LBRACE, lx_pos, 1, b, 3'd0);
    end else if (b == CH_RBRACE) begin
      put_tok(KIND_RBRACE, lx_pos, 1, b, 3'd0);
    end else if (b == CH_COMMA) begin
      put_tok(KIND_COMMA, lx_pos, 1, b, 3'd0);
    end else if (b == CH_PLUS || b == CH_MINUS || b == CH_STAR || b == CH_SLASH) begin
      put_tok(KIND_OP, lx_pos, 1, b, 3'd0);
    end else begin
      open_lexeme(M_WORD, b);
    end
  endtask

  // tokens caused by one source byte, in output order
  task automatic lex_byte(logic [7:0] b, logic eot);
    logic [4:0] kind;
    byte_tokens.delete();
    case (lx_mode)
      M_STR: begin
        if (b == CH_QUOTE) begin
          put_tok(KIND_STRING, lx_start, lx_len, lx_first, 3'd0);
          lx_mode = M_IDLE;
        end else begin
          if (lx_len == 0) lx_first = b;
          grow_lexeme(b);
        end
      end
      M_NUM: begin
        if (num_char(b)) begin
          grow_lexeme(b);
        end else begin
          put_tok(KIND_NUMBER, lx_start, lx_len, lx_first, 3'd0);
          lx_mode = M_IDLE;
          start_token(b);
        end
      end
      M_WORD: begin
        if (word_char(b)) begin
          grow_lexeme(b);
        end else begin
          put_word();
          lx_mode = M_IDLE;
          start_token(b);
        end
      end
      M_LOOK: begin
        if (b == CH_EQ) begin
          case (lx_first)
            CH_EQ:   kind = KIND_EQEQ;
            CH_GT:   kind = KIND_GE;
            CH_LT:   kind = KIND_LE;
            default: kind = KIND_NE;
          endcase
          put_tok(kind, lx_start, 2, lx_first, 3'd0);
          lx_mode = M_IDLE;
        end else begin
          put_look_alone();
          lx_mode = M_IDLE;
          start_token(b);
        end
      end
      default: begin
        lx_mode = M_IDLE;
        start_token(b);
      end
    endcase
    if (eot) begin
      case (lx_mode)
        M_STR:   put_tok(KIND_UNTERMINATED, lx_start, lx_len, lx_first, 3'd0);
        M_NUM:   put_tok(KIND_NUMBER, lx_start, lx_len, lx_first, 3'd0);
        M_WORD:  put_word();
        M_LOOK:  put_look_alone();
        default: ;
      endcase
      lx_mode  = M_IDLE;
      lx_start = '0;
      lx_len   = 0;
      lx_first = 8'd0;
      lx_pos   = '0;
    end else begin
      lx_pos = lx_pos + 1'b1;
    end
    if (byte_tokens.size() != 0) byte_tokens[byte_tokens.size()-1].last = 1'b1;
  endtask

  task automatic flag_mismatch(string what, int got, int want);
    if (mismatches < 200)
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // stimulus building
  task automatic add_byte(logic [7:0] b);
    stim_row_t r;
    r.ch      = b;
    r.eot     = 1'b0;
    r.n_typed = PRED;
    r.t0      = NO_TOK;
    r.t1      = NO_TOK;
    stim_q = {stim_q, r};
  endtask

  task automatic add_text(string s);
    foreach (s[i]) add_byte(s[i]);
  endtask

  function automatic logic [7:0] any_alnum();
    case ($urandom_range(0, 2))
      0:       return 8'h30 + 8'($urandom_range(0, 9));
      1:       return 8'h41 + 8'($urandom_range(0, 25));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] any_blank();
    if ($urandom_range(0, 2) == 0) return 8'd9 + 8'($urandom_range(0, 4));
    return CH_SPACE;
  endfunction

  function automatic logic [7:0] word_lead();
    logic [7:0] b;
    if ($urandom_range(0, 3) != 0) return 8'h61 + 8'($urandom_range(0, 25));
    do begin
      b = 8'($urandom_range(0, 255));
    end while (num_char(b) || blank_char(b) || b == CH_QUOTE || b == CH_EQ || b == CH_GT ||
               b == CH_LT || b == CH_BANG || b == CH_LBRACE || b == CH_RBRACE ||
               b == CH_COMMA || b == CH_PLUS || b == CH_MINUS || b == CH_STAR ||
               b == CH_SLASH);
    return b;
  endfunction

  function automatic logic [7:0] str_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CH_QUOTE);
    return b;
  endfunction

  task automatic build_stimulus();
    string s;
    int    n;
    dir_tab = '{
      '{CH_LBRACE, 1'b0, 1, lx(KIND_LBRACE, 16'd0, 16'd1, CH_LBRACE, 3'd0, 1'b1), NO_TOK},
      '{"7",       1'b0, PRED, NO_TOK, NO_TOK},
      '{"9",       1'b0, PRED, NO_TOK, NO_TOK},
      '{CH_QUOTE,  1'b1, 2, lx(KIND_NUMBER, 16'd1, 16'd2, "7", 3'd0, 1'b0),
                            lx(KIND_UNTERMINATED, 16'd4, 16'd0, 8'd0, 3'd0, 1'b1)},
      '{CH_QUOTE,  1'b0, PRED, NO_TOK, NO_TOK},
      '{CH_QUOTE,  1'b0, PRED, NO_TOK, NO_TOK},
      '{CH_BANG,   1'b0, PRED, NO_TOK, NO_TOK},
      '{CH_LBRACE, 1'b0, PRED, NO_TOK, NO_TOK},
      '{CH_EQ,     1'b0, PRED, NO_TOK, NO_TOK},
      '{CH_EQ,     1'b0, PRED, NO_TOK, NO_TOK},
      '{CH_GT,     1'b0, PRED, NO_TOK, NO_TOK},
      '{CH_EQ,     1'b0, PRED, NO_TOK, NO_TOK},
      '{CH_LT,     1'b0, PRED, NO_TOK, NO_TOK},
      '{CH_RBRACE, 1'b0, PRED, NO_TOK, NO_TOK},
      '{"R",       1'b0, PRED, NO_TOK, NO_TOK},
      '{"8",       1'b0, PRED, NO_TOK, NO_TOK},
      '{CH_COMMA,  1'b0, PRED, NO_TOK, NO_TOK},
      '{8'hFF,     1'b0, PRED, NO_TOK, NO_TOK},
      '{8'h80,     1'b0, PRED, NO_TOK, NO_TOK},
      '{8'h00,     1'b0, PRED, NO_TOK, NO_TOK},
      '{CH_PLUS,   1'b0, PRED, NO_TOK, NO_TOK},
      '{CH_GT,     1'b1, PRED, NO_TOK, NO_TOK},
      '{"w",       1'b0, PRED, NO_TOK, NO_TOK},
      '{"1",       1'b1, PRED, NO_TOK, NO_TOK},
      '{CH_BANG,   1'b1, 1, lx(KIND_UNKNOWN, 16'd0, 16'd1, CH_BANG, 3'd0, 1'b1), NO_TOK}
    };
    foreach (dir_tab[i]) stim_q = {stim_q, dir_tab[i]};

    while (stim_q.size() < DIR_ROWS + RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          s = kw_text[$urandom_range(0, KW_TOTAL - 1)];
          case ($urandom_range(0, 7))
            0:       s = {s, string'(any_alnum())};
            1:       s = {s, string'(any_alnum()), string'(any_alnum())};
            2:       s = s.substr(0, s.len() - 2);
            default: ;
          endcase
          add_text(s);
        end
        2, 3: begin
          n = $urandom_range(1, 6);
          repeat (n) add_byte(8'h30 + 8'($urandom_range(0, 9)));
        end
        4: begin
          add_byte(word_lead());
          n = $urandom_range(0, 9);
          repeat (n) add_byte(any_alnum());
        end
        5: begin
          add_byte(CH_QUOTE);
          n = $urandom_range(0, 6);
          repeat (n) add_byte(str_byte());
          if ($urandom_range(0, 9) != 0) add_byte(CH_QUOTE);
        end
        6: begin
          add_byte(look_chars[$urandom_range(0, 3)]);
          if ($urandom_range(0, 1) != 0) add_byte(CH_EQ);
        end
        7: add_byte(single_chars[$urandom_range(0, 6)]);
        8: add_byte(any_blank());
        default: add_byte(8'($urandom_range(0, 255)));
      endcase
      if ($urandom_range(0, 1) != 0) add_byte(any_blank());
      if ($urandom_range(0, 19) == 0) stim_q[stim_q.size()-1].eot = 1'b1;
    end
    calm_from = stim_q.size() - 100;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // byte source
  always @(posedge clk) begin
    int nxt;
    if (rst) begin
      chars.valid <= 1'b0;
      src_gap = 0;
    end else begin
      nxt = stim_idx + ((chars.valid && chars.ready) ? 1 : 0);
      stim_idx <= nxt;
      if (!chars.valid || chars.ready) begin
        if (src_gap != 0) begin
          src_gap--;
          chars.valid <= 1'b0;
        end else if (nxt >= stim_q.size()) begin
          chars.valid <= 1'b0;
        end else if (!hold_sink && nxt < calm_from && ((nxt / 97) % 4) != 2 &&
                     $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 16);
          chars.valid <= 1'b0;
        end else begin
          chars.valid       <= 1'b1;
          chars.char_byte   <= stim_q[nxt].ch;
          chars.end_of_text <= stim_q[nxt].eot;
        end
      end
    end
  end

  // token sink
  always @(posedge clk) begin
    if (rst) begin
      tokens.ready <= 1'b0;
      snk_gap = 0;
    end else if (hold_sink) begin
      tokens.ready <= 1'b0;
    end else if (snk_gap != 0) begin
      snk_gap--;
      tokens.ready <= 1'b0;
    end else if (stim_idx < calm_from && ((stim_idx / 89) % 4) != 1 &&
                 $urandom_range(0, 7) == 0) begin
      snk_gap = $urandom_range(0, 16);
      tokens.ready <= 1'b0;
    end else begin
      tokens.ready <= 1'b1;
    end
  end

  // long receiver hold-off so the output queue fills and input stalls
  initial begin
    hold_sink = 1'b0;
    wait (stim_idx >= PRESSURE_AT);
    @(posedge clk);
    hold_sink <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_sink <= 1'b0;
  end

  // prediction and comparison
  always @(posedge clk) begin
    lexeme_t want;
    if (!rst) begin
      if (chars.valid && chars.ready) begin
        lex_byte(chars.char_byte, chars.end_of_text);
        if (stim_q[stim_idx].n_typed == PRED) begin
          foreach (byte_tokens[i]) expected_tokens = {expected_tokens, byte_tokens[i]};
        end else begin
          if (stim_q[stim_idx].n_typed >= 1)
            expected_tokens = {expected_tokens, stim_q[stim_idx].t0};
          if (stim_q[stim_idx].n_typed >= 2)
            expected_tokens = {expected_tokens, stim_q[stim_idx].t1};
        end
      end
      if (tokens.valid && tokens.ready) begin
        if (expected_tokens.size() == 0) begin
          flag_mismatch("unexpected token, kind", tokens.token_kind, -1);
        end else begin
          want = expected_tokens.pop_front();
          if (tokens.token_kind !== want.kind)
            flag_mismatch("token_kind", tokens.token_kind, want.kind);
          if (tokens.token_start !== want.start)
            flag_mismatch("token_start", tokens.token_start, want.start);
          if (tokens.token_length !== want.length)
            flag_mismatch("token_length", tokens.token_length, want.length);
          if (tokens.token_char !== want.chr)
            flag_mismatch("token_char", tokens.token_char, want.chr);
          if (tokens.register_index !== want.reg_idx)
            flag_mismatch("register_index", tokens.register_index, want.reg_idx);
          if (tokens.last_of_run !== want.last)
            flag_mismatch("last_of_run", tokens.last_of_run, want.last);
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (!rst && !draining) begin
      if ((chars.valid && chars.ready) || (tokens.valid && tokens.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("keyword_lexer_stream_tb failed");
          $finish;
        end
      end
    end
  end

  initial begin
    rst      = 1'b1;
    draining = 1'b0;
    build_stimulus();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (stim_idx == stim_q.size());
    wait (expected_tokens.size() == 0);
    draining <= 1'b1;
    repeat (16) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("keyword_lexer_stream_tb passed");
    end else begin
      $display("keyword_lexer_stream_tb failed");
    end
    $finish;
  end

endmodule
